// ===== rtl/core/epd_pkg.sv =====
`timescale 1ns / 1ps
package epd_pkg;

    localparam int COUNT_WIDTH_DEF    = 20;
    localparam int GAIN_FRAC_BITS_DEF = 4;
    localparam int SPEED_MAX_DEF      = 255;

    localparam int CMD_W    = 2;
    localparam int CELLS_W  = 8;
    localparam int GAIN_W   = 12;
    localparam int TPC_W    = 10;
    localparam int DB_W     = 8;
    localparam int TARGET_W = CELLS_W + TPC_W;
    localparam int OUT_W    = 32;
    localparam int DIR_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CTRL  = 2'd2;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TPC      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd3;

    localparam logic [GAIN_W-1:0] KP_RESET  = 12'd64;
    localparam logic [GAIN_W-1:0] KD_RESET  = 12'd96;
    localparam logic [TPC_W-1:0]  TPC_RESET = 10'd500;
    localparam logic [DB_W-1:0]   DB_RESET  = 8'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [TPC_W-1:0]  tpc;
        logic [DB_W-1:0]   deadband;
    } t_cfg;

    // registered input word: command, count direction, scaled target
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                up;
        logic [TARGET_W-1:0] target;
    } t_item;

endpackage

// ===== rtl/core/epd_item_if.sv =====
`timescale 1ns / 1ps
interface epd_item_if;
    import epd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic               chan_a;
    logic               chan_b;
    logic [CELLS_W-1:0] target_cells;

    modport source (output valid, cmd, chan_a, chan_b, target_cells, input ready);
    modport sink   (input valid, cmd, chan_a, chan_b, target_cells, output ready);
endinterface

// ===== rtl/core/epd_result_if.sv =====
`timescale 1ns / 1ps
interface epd_result_if #(
    parameter int SPEED_W = 8
);
    import epd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] control_out;
    logic [SPEED_W-1:0]      drive_speed;
    logic [DIR_W-1:0]        drive_dir;
    logic                    at_target;

    modport source (output valid, control_out, drive_speed, drive_dir, at_target,
                    input ready);
    modport sink   (input valid, control_out, drive_speed, drive_dir, at_target,
                    output ready);
endinterface

// ===== rtl/core/epd_cfg_regs.sv =====
`timescale 1ns / 1ps
module epd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [epd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [epd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output epd_pkg::t_cfg                    o_cfg
);
    import epd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp       <= KP_RESET;
            r_cfg.kd       <= KD_RESET;
            r_cfg.tpc      <= TPC_RESET;
            r_cfg.deadband <= DB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KP:       r_cfg.kp       <= i_cfg_data[GAIN_W-1:0];
                REG_KD:       r_cfg.kd       <= i_cfg_data[GAIN_W-1:0];
                REG_TPC:      r_cfg.tpc      <= i_cfg_data[TPC_W-1:0];
                REG_DEADBAND: r_cfg.deadband <= i_cfg_data[DB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/epd_in_stage.sv =====
`timescale 1ns / 1ps
module epd_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [epd_pkg::CMD_W-1:0]     i_cmd,
    input  logic                          i_chan_a,
    input  logic                          i_chan_b,
    input  logic [epd_pkg::CELLS_W-1:0]   i_target_cells,
    input  logic [epd_pkg::TPC_W-1:0]     i_tpc,
    input  logic                          i_slot_free,
    output logic                          o_go,
    output epd_pkg::t_item                o_item
);
    import epd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    // edge words never need the result slot, so only control ticks wait on it
    assign o_go    = r_valid && ((r_item.cmd != CMD_CTRL) || i_slot_free);
    assign o_ready = !r_valid || o_go;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_item.cmd    = i_cmd;
        n_item.up     = i_chan_a & ~i_chan_b;
        n_item.target = TARGET_W'(i_target_cells) * TARGET_W'(i_tpc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !o_go);
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/core/epd_counters.sv =====
`timescale 1ns / 1ps
module epd_counters #(
    parameter int COUNT_WIDTH = epd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  epd_pkg::t_item                i_item,
    output logic signed [COUNT_WIDTH-1:0] o_left,
    output logic signed [COUNT_WIDTH-1:0] o_right
);
    import epd_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_HI = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_LO = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic signed [COUNT_WIDTH-1:0] r_left;
    logic signed [COUNT_WIDTH-1:0] r_right;
    logic signed [COUNT_WIDTH-1:0] n_left;
    logic signed [COUNT_WIDTH-1:0] n_right;

    function automatic logic signed [COUNT_WIDTH-1:0] step_sat(
        input logic signed [COUNT_WIDTH-1:0] c,
        input logic                          up
    );
        if (up) begin
            return (c != CNT_HI) ? c + 1'b1 : c;
        end
        return (c != CNT_LO) ? c - 1'b1 : c;
    endfunction

    assign n_left  = step_sat(r_left, i_item.up);
    assign n_right = step_sat(r_right, i_item.up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_go) begin
            if (i_item.cmd == CMD_LEFT) begin
                r_left <= n_left;
            end
            if (i_item.cmd == CMD_RIGHT) begin
                r_right <= n_right;
            end
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== rtl/core/epd_pd_core.sv =====
`timescale 1ns / 1ps
module epd_pd_core #(
    parameter int COUNT_WIDTH    = epd_pkg::COUNT_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = epd_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SPEED_MAX      = epd_pkg::SPEED_MAX_DEF,
    parameter int SPEED_W        = $clog2(SPEED_MAX + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  epd_pkg::t_item                      i_item,
    input  epd_pkg::t_cfg                       i_cfg,
    input  logic signed [COUNT_WIDTH-1:0]       i_left,
    input  logic signed [COUNT_WIDTH-1:0]       i_right,
    input  logic                                i_out_ready,
    output logic                                o_slot_free,
    output logic                                o_valid,
    output logic signed [epd_pkg::OUT_W-1:0]    o_control_out,
    output logic [SPEED_W-1:0]                  o_drive_speed,
    output logic [epd_pkg::DIR_W-1:0]           o_drive_dir,
    output logic                                o_at_target
);
    import epd_pkg::*;

    // error width: signed target vs. signed average, plus one for the difference
    localparam int EW = ((COUNT_WIDTH > TARGET_W + 1) ? COUNT_WIDTH : TARGET_W + 1) + 1;
    localparam int DW = EW + 1;
    localparam int PW = EW + GAIN_W + 3;
    localparam logic signed [PW-1:0] RND_BIAS = PW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [PW-1:0] U_MAX = {{(PW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [PW-1:0] U_MIN = {{(PW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic signed [EW-1:0]          r_prev;
    logic                          r_valid;
    logic signed [OUT_W-1:0]       r_u;
    logic [SPEED_W-1:0]            r_speed;
    logic [DIR_W-1:0]              r_dir;
    logic                          r_at;

    logic signed [COUNT_WIDTH:0]   sum_cnt;
    logic signed [COUNT_WIDTH:0]   sum_adj;
    logic signed [COUNT_WIDTH-1:0] avg_cnt;
    logic signed [EW-1:0]          err;
    logic [EW-1:0]                 err_mag;
    logic                          in_band;
    logic signed [DW-1:0]          d_err;
    logic signed [EW+GAIN_W:0]     prod_p;
    logic signed [DW+GAIN_W:0]     prod_d;
    logic signed [PW-1:0]          u_raw;
    logic signed [PW-1:0]          u_adj;
    logic signed [PW-1:0]          u_q;
    logic signed [OUT_W-1:0]       u_sat;
    logic [OUT_W-1:0]              u_mag;
    logic [SPEED_W-1:0]            n_speed;
    logic [DIR_W-1:0]              n_dir;
    logic                          fire;

    always_comb begin
        sum_cnt = {i_left[COUNT_WIDTH-1], i_left} + {i_right[COUNT_WIDTH-1], i_right};
        // halve toward zero
        sum_adj = sum_cnt + {{COUNT_WIDTH{1'b0}}, sum_cnt[COUNT_WIDTH]};
        avg_cnt = sum_adj[COUNT_WIDTH:1];
        err     = $signed({{(EW-TARGET_W){1'b0}}, i_item.target})
                - $signed({{(EW-COUNT_WIDTH){avg_cnt[COUNT_WIDTH-1]}}, avg_cnt});
        err_mag = err[EW-1] ? EW'(-err) : err;
        in_band = err_mag < {{(EW-DB_W){1'b0}}, i_cfg.deadband};

        d_err  = {err[EW-1], err} - {r_prev[EW-1], r_prev};
        prod_p = err * $signed({1'b0, i_cfg.kp});
        prod_d = d_err * $signed({1'b0, i_cfg.kd});
        u_raw  = PW'(prod_p) + PW'(prod_d);
        u_adj  = u_raw[PW-1] ? u_raw + RND_BIAS : u_raw;
        u_q    = u_adj >>> GAIN_FRAC_BITS;

        if (u_q > U_MAX) begin
            u_sat = U_MAX[OUT_W-1:0];
        end else if (u_q < U_MIN) begin
            u_sat = U_MIN[OUT_W-1:0];
        end else begin
            u_sat = u_q[OUT_W-1:0];
        end

        u_mag   = u_sat[OUT_W-1] ? OUT_W'(-u_sat) : u_sat;
        n_speed = (u_mag > OUT_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : u_mag[SPEED_W-1:0];

        if (u_sat[OUT_W-1]) begin
            n_dir = DIR_BACK;
        end else if (u_sat != '0) begin
            n_dir = DIR_FWD;
        end else begin
            n_dir = DIR_STOP;
        end
    end

    assign fire        = i_go && (i_item.cmd == CMD_CTRL);
    assign o_slot_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (fire && !in_band) begin
                r_prev <= err;
            end
        end
        if (fire) begin
            if (in_band) begin
                r_u     <= '0;
                r_speed <= '0;
                r_dir   <= DIR_STOP;
                r_at    <= 1'b1;
            end else begin
                r_u     <= u_sat;
                r_speed <= n_speed;
                r_dir   <= n_dir;
                r_at    <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_control_out = r_u;
    assign o_drive_speed = r_speed;
    assign o_drive_dir   = r_dir;
    assign o_at_target   = r_at;

endmodule

// ===== rtl/core/encoder_pd_distance_drive_unit.sv =====
`timescale 1ns / 1ps
// Wheel tick counters with a PD distance controller for a two-wheel drive.
// i_item carries one word per event: a left or right encoder edge (with the
// A/B levels seen at the edge) or a control tick with a target in cells.
// Edge words update the saturating tick counters and produce nothing; each
// control tick produces exactly one word on o_result: signed PD output,
// drive speed (|output| clamped to SPEED_MAX), direction and at-target flag.
// Gains, ticks per cell and deadband are written through i_cfg_*; the user
// must do so only while idle, as the block itself does not enforce it.
// Throughput: one word per cycle while i_item is ready. A control tick passes
// through an input register (target scaling), then the error/PD math into the
// result register, with counters and last error updated in the same cycle.
// A stalled o_result holds its word; edge words keep flowing past it, and
// i_item drops ready only when a control tick waits behind a full result
// register.
// Reset: counters and last error clear, registers take their default values
// (kp 4.0, kd 6.0, 500 ticks per cell, deadband 3) and the pipeline empties.
module encoder_pd_distance_drive_unit #(
    parameter int COUNT_WIDTH    = epd_pkg::COUNT_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = epd_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SPEED_MAX      = epd_pkg::SPEED_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [epd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [epd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    epd_item_if.sink                        i_item,
    epd_result_if.source                    o_result
);
    import epd_pkg::*;

    localparam int SPEED_W = $clog2(SPEED_MAX + 1);

    t_cfg                          cfg;
    t_item                         item;
    logic                          go;
    logic                          slot_free;
    logic signed [COUNT_WIDTH-1:0] left_cnt;
    logic signed [COUNT_WIDTH-1:0] right_cnt;

    epd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    epd_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_item.valid),
        .o_ready        (i_item.ready),
        .i_cmd          (i_item.cmd),
        .i_chan_a       (i_item.chan_a),
        .i_chan_b       (i_item.chan_b),
        .i_target_cells (i_item.target_cells),
        .i_tpc          (cfg.tpc),
        .i_slot_free    (slot_free),
        .o_go           (go),
        .o_item         (item)
    );

    epd_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (item),
        .o_left  (left_cnt),
        .o_right (right_cnt)
    );

    epd_pd_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SPEED_MAX      (SPEED_MAX),
        .SPEED_W        (SPEED_W)
    ) u_pd (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_item        (item),
        .i_cfg         (cfg),
        .i_left        (left_cnt),
        .i_right       (right_cnt),
        .i_out_ready   (o_result.ready),
        .o_slot_free   (slot_free),
        .o_valid       (o_result.valid),
        .o_control_out (o_result.control_out),
        .o_drive_speed (o_result.drive_speed),
        .o_drive_dir   (o_result.drive_dir),
        .o_at_target   (o_result.at_target)
    );

    a_ctrl_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (item.cmd == CMD_CTRL) |=> o_result.valid)
        else $error("control tick did not load a result word");

    a_edge_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (item.cmd != CMD_CTRL) && !o_result.valid |=> !o_result.valid)
        else $error("non-control word produced a result");

    a_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.at_target
            |-> (o_result.control_out == '0) && (o_result.drive_dir == DIR_STOP))
        else $error("at-target word with nonzero drive");

    a_dir_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid
            |-> ((o_result.control_out == '0) == (o_result.drive_dir == DIR_STOP)))
        else $error("direction disagrees with control output");

endmodule

// ===== bench/tb_encoder_pd_distance_drive_unit.sv =====
`timescale 1ns / 1ps
import epd_pkg::*;

typedef struct packed {
    logic signed [OUT_W-1:0] control;
    logic [7:0]              speed;
    logic [DIR_W-1:0]        dir;
    logic                    at_target;
} t_drive;

// Tracks wheel counts, last error and gains; predicts one drive word per control tick.
class pd_drive_tracker;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [TPC_W-1:0]  ticks_per_cell;
    logic [DB_W-1:0]   deadband;
    longint            left_ticks;
    longint            right_ticks;
    longint            last_error;
    t_drive            pending_drive[$];
    int                mismatches;

    function new();
        kp_gain        = KP_RESET;
        kd_gain        = KD_RESET;
        ticks_per_cell = TPC_RESET;
        deadband       = DB_RESET;
        left_ticks     = 0;
        right_ticks    = 0;
        last_error     = 0;
        mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KP:       kp_gain = data;
            REG_KD:       kd_gain = data;
            REG_TPC:      ticks_per_cell = data[TPC_W-1:0];
            REG_DEADBAND: deadband = data[DB_W-1:0];
            default: ;
        endcase
    endfunction

    // saturating signed COUNT_WIDTH_DEF-bit counter
    function longint step_count(longint count, bit up);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COUNT_WIDTH_DEF - 1)) - 1;
        lo = -(longint'(1) << (COUNT_WIDTH_DEF - 1));
        if (up)
            return (count < hi) ? count + 1 : hi;
        return (count > lo) ? count - 1 : lo;
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic a, logic b,
                            logic [CELLS_W-1:0] cells);
        bit     up;
        longint target;
        longint err;
        longint mag;
        longint u;
        longint speed;
        t_drive d;
        up = a & ~b;
        case (cmd)
            CMD_LEFT:  left_ticks = step_count(left_ticks, up);
            CMD_RIGHT: right_ticks = step_count(right_ticks, up);
            CMD_CTRL: begin
                target = longint'(cells) * longint'(ticks_per_cell);
                err = target - (left_ticks + right_ticks) / 2;
                mag = (err < 0) ? -err : err;
                if (mag < longint'(deadband)) begin
                    d = '{control: '0, speed: '0, dir: DIR_STOP, at_target: 1'b1};
                end else begin
                    u = longint'(kp_gain) * err + longint'(kd_gain) * (err - last_error);
                    u = u / (longint'(1) << GAIN_FRAC_BITS_DEF);
                    if (u > longint'(32'sh7fff_ffff))
                        u = longint'(32'sh7fff_ffff);
                    if (u < longint'(32'sh8000_0000))
                        u = longint'(32'sh8000_0000);
                    last_error = err;
                    speed = (u < 0) ? -u : u;
                    if (speed > SPEED_MAX_DEF)
                        speed = SPEED_MAX_DEF;
                    d.control   = u[OUT_W-1:0];
                    d.speed     = speed[7:0];
                    d.dir       = (u > 0) ? DIR_FWD : ((u < 0) ? DIR_BACK : DIR_STOP);
                    d.at_target = 1'b0;
                end
                pending_drive.push_back(d);
            end
            default: ;
        endcase
    endfunction

    function void check_word(logic signed [OUT_W-1:0] control, logic [7:0] speed,
                             logic [DIR_W-1:0] dir, logic at_target);
        t_drive exp;
        if (pending_drive.size() == 0) begin
            $error("drive word with none expected: control_out %0d", control);
            mismatches++;
            return;
        end
        exp = pending_drive.pop_front();
        if (control !== exp.control) begin
            $error("control_out: expected %0d, got %0d", $signed(exp.control), control);
            mismatches++;
        end
        if (speed !== exp.speed) begin
            $error("drive_speed: expected %0d, got %0d", exp.speed, speed);
            mismatches++;
        end
        if (dir !== exp.dir) begin
            $error("drive_dir: expected %0d, got %0d", exp.dir, dir);
            mismatches++;
        end
        if (at_target !== exp.at_target) begin
            $error("at_target: expected %0d, got %0d", exp.at_target, at_target);
            mismatches++;
        end
    endfunction
endclass

module tb_encoder_pd_distance_drive_unit;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 550;
    localparam int PHASES        = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int SPEED_W       = 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    cycle_count = 0;
    bit                    hold_req;
    pd_drive_tracker       tracker;

    epd_item_if                             item_if ();
    epd_result_if #(.SPEED_W(SPEED_W))      res_if ();

    encoder_pd_distance_drive_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_word(logic [CMD_W-1:0] cmd, logic a, logic b,
                             logic [CELLS_W-1:0] cells);
        item_if.valid        <= 1'b1;
        item_if.cmd          <= cmd;
        item_if.chan_a       <= a;
        item_if.chan_b       <= b;
        item_if.target_cells <= cells;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        tracker.note_word(cmd, a, b, cells);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            item_if.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_edge(logic [CMD_W-1:0] cmd, logic a, logic b);
        send_word(cmd, a, b, CELLS_W'($urandom_range(0, 255)));
    endtask

    // wait out all drive words, then let edge words still in flight settle
    task automatic drain();
        pause(1);
        while (tracker.pending_drive.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        tracker.write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic write_cfg(int kp, int kd, int tpc, int db);
        cfg_reg(REG_KP, kp);
        cfg_reg(REG_KD, kd);
        cfg_reg(REG_TPC, tpc);
        cfg_reg(REG_DEADBAND, db);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_word(res_if.control_out, res_if.drive_speed, res_if.drive_dir,
                               res_if.at_target);
    end

    // receiver: ready patterns from random 16-bit words, plus one long hold-off on request
    initial begin : receiver
        logic [15:0] pattern;
        int          left;
        left = 0;
        pattern = '1;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0: pattern = '1;
                    1: pattern = 16'($urandom);
                    2: pattern = 16'($urandom | $urandom);
                    default: pattern = 16'($urandom & $urandom);
                endcase
                left = 16;
            end
            res_if.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
            left--;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int               sent;
        int               burst;
        int               trend;
        int               pick;
        int               tpc;
        int               db;
        logic [CMD_W-1:0] cmd;
        logic             a;
        logic             b;
        logic [CELLS_W-1:0] cells;

        tracker = new();
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= REG_KP;
        cfg_data             <= '0;
        item_if.valid        <= 1'b0;
        item_if.cmd          <= CMD_LEFT;
        item_if.chan_a       <= 1'b0;
        item_if.chan_b       <= 1'b0;
        item_if.target_cells <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: in deadband at zero, then full target
        send_word(CMD_CTRL, 1'b0, 1'b1, 8'd0);
        send_word(CMD_CTRL, 1'b1, 1'b1, 8'd255);
        send_edge(CMD_LEFT, 1'b1, 1'b0);
        send_edge(CMD_RIGHT, 1'b1, 1'b0);
        send_edge(CMD_LEFT, 1'b0, 1'b1);
        send_edge(CMD_LEFT, 1'b0, 1'b0);
        send_edge(CMD_RIGHT, 1'b1, 1'b1);
        send_edge(CMD_LEFT, 1'b0, 1'b0);
        send_word(CMD_UNUSED, 1'b1, 1'b0, 8'd255);
        send_word(CMD_CTRL, 1'b1, 1'b0, 8'd0);
        // derivative term drags the output backward
        send_word(CMD_CTRL, 1'b0, 1'b0, 8'd1);
        drain();

        // zero ticks per cell, zero deadband: output truncates to zero outside deadband
        write_cfg(1, 0, 0, 0);
        send_edge(CMD_RIGHT, 1'b1, 1'b0);
        send_word(CMD_CTRL, 1'b0, 1'b0, 8'd200);
        send_edge(CMD_LEFT, 1'b0, 1'b1);
        send_word(CMD_CTRL, 1'b1, 1'b1, 8'd170);
        drain();

        write_cfg(4095, 4095, 1023, 255);
        send_word(CMD_CTRL, 1'b0, 1'b0, 8'd255);
        send_word(CMD_CTRL, 1'b0, 1'b0, 8'd0);
        send_word(CMD_CTRL, 1'b0, 1'b0, 8'd1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: tpc = 0;
                1: tpc = 1023;
                2: tpc = $urandom_range(1, 1023);
                default: tpc = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0: db = 0;
                1: db = 255;
                default: db = $urandom_range(1, 40);
            endcase
            write_cfg(pick_gain(), pick_gain(), tpc, db);
            if (ph == 0)
                hold_req = 1'b1;
            trend = $urandom_range(0, 2);
            sent = 0;
            burst = $urandom_range(1, 16);
            while (sent < RANDOM_WORDS / PHASES) begin
                if (burst == 0) begin
                    pause($urandom_range(1, 10));
                    burst = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
                end
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    cmd = CMD_UNUSED;
                else if (pick < 30)
                    cmd = CMD_CTRL;
                else if (pick < 65)
                    cmd = CMD_LEFT;
                else
                    cmd = CMD_RIGHT;
                a = 1'($urandom_range(0, 1));
                b = 1'($urandom_range(0, 1));
                // bias the wheels up or down for a whole phase
                if (trend == 1 && $urandom_range(0, 3) != 0) begin
                    a = 1'b1;
                    b = 1'b0;
                end else if (trend == 2 && a && !b && $urandom_range(0, 3) != 0) begin
                    a = 1'b0;
                    b = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    cells = '0;
                else if (pick == 3)
                    cells = '1;
                else
                    cells = CELLS_W'($urandom_range(0, 255));
                send_word(cmd, a, b, cells);
                burst--;
                if (cmd != CMD_UNUSED)
                    sent++;
            end
            drain();
        end

        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
